@@ rtl/kmd_pkg.sv @@
// ----------------------------------------------------------------------------
// kmd_pkg
// shared types, widths and codes of the key matrix debouncer
// ----------------------------------------------------------------------------
package kmd_pkg;

	localparam int ROWS_DEF    = 3;
	localparam int COLUMNS_DEF = 4;

	// field widths fixed by the beat formats
	localparam int ROW_W     = 2;
	localparam int MASK_W    = 4;
	localparam int COL_W     = 2;
	localparam int CNT_W     = 8;
	localparam int TKEY_W    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;
	localparam int KEY_IDX_W = 6;

	// one lane of a row word: stable bit above the mismatch counter
	localparam int LANE_W    = CNT_W + 1;
	localparam int MAX_LANES = MASK_W;

	localparam logic [CNT_W-1:0] THRESHOLD_RST = 8'd20;

	// record queue between the update stage and the output
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	// pending slots of a record: two per lane, switch event first
	localparam int SLOT_N = 2 * MAX_LANES;
	localparam int SLOT_W = $clog2(SLOT_N);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD  = 2'd0,
		REG_TOGGLE_KEY = 2'd1,
		REG_TOGGLE_EN  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		EVT_KEY    = 1'b0,
		EVT_SWITCH = 1'b1
	} evt_kind_t;

	// events caused by one row beat
	typedef struct packed {
		logic [ROW_W-1:0]     row;
		logic [MAX_LANES-1:0] key_evt;
		logic [MAX_LANES-1:0] tog_evt;
		logic [MAX_LANES-1:0] new_val;
		logic                 sw_prev;
	} kmd_rec_t;

	typedef struct packed {
		logic [CNT_W-1:0]  threshold;
		logic [TKEY_W-1:0] toggle_key;
		logic              toggle_en;
	} kmd_cfg_t;

endpackage

@@ rtl/kmd_if.sv @@
// ----------------------------------------------------------------------------
// kmd_if
// valid/ready channels of the key matrix debouncer
// ----------------------------------------------------------------------------
interface kmd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] row_index;
	logic [3:0] pressed_mask;

	modport source (output valid, output row_index, output pressed_mask, input ready);
	modport sink (input valid, input row_index, input pressed_mask, output ready);
endinterface

interface kmd_out_if;
	logic       valid;
	logic       ready;
	logic       event_kind;
	logic [1:0] key_row;
	logic [1:0] key_column;
	logic       now_pressed;
	logic       switch_on;
	logic       last_of_run;

	modport source (output valid, output event_kind, output key_row, output key_column,
		output now_pressed, output switch_on, output last_of_run, input ready);
	modport sink (input valid, input event_kind, input key_row, input key_column,
		input now_pressed, input switch_on, input last_of_run, output ready);
endinterface

@@ rtl/kmd_row_mem.sv @@
// ----------------------------------------------------------------------------
// kmd_row_mem
// per-row key state memory, one row word per entry, registered read
// ----------------------------------------------------------------------------
module kmd_row_mem
	import kmd_pkg::*;
#(
	parameter int ROWS  = ROWS_DEF,
	parameter int LANES = MAX_LANES,
	localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1,
	localparam int DW   = LANES * LANE_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0]   mem [ROWS];
	logic [ROWS-1:0] vld_q;
	logic [DW-1:0]   rdata_q;
	logic            rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// rows never written read as all released, counters zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

@@ rtl/kmd_update.sv @@
// ----------------------------------------------------------------------------
// kmd_update
// debounce update of one row word, all lanes side by side
// ----------------------------------------------------------------------------
module kmd_update
	import kmd_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int LANES   = MAX_LANES,
	localparam int DW     = LANES * LANE_W
) (
	input  logic [DW-1:0]     row_word,
	input  logic [ROW_W-1:0]  row,
	input  logic [MASK_W-1:0] mask,
	input  kmd_cfg_t          cfg,
	input  logic              sw,
	output logic [DW-1:0]     new_word,
	output kmd_rec_t          rec,
	output logic              sw_after
);

	logic [MAX_LANES-1:0] key_evt;
	logic [MAX_LANES-1:0] tog_evt;
	logic [MAX_LANES-1:0] new_val;

	always_comb begin
		logic             stable;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] cnt_inc;
		logic             smp;
		logic [KEY_IDX_W-1:0] key;
		new_word = row_word;
		key_evt  = '0;
		tog_evt  = '0;
		new_val  = '0;
		for (int c = 0; c < LANES; c++) begin
			stable  = row_word[c*LANE_W + CNT_W];
			cnt     = row_word[c*LANE_W +: CNT_W];
			smp     = mask[c];
			key     = KEY_IDX_W'(row) * KEY_IDX_W'(COLUMNS) + KEY_IDX_W'(c);
			cnt_inc = (cnt < cfg.threshold) ? cnt + 1'b1 : cnt;
			new_val[c] = stable;
			if (smp == stable) begin
				new_word[c*LANE_W +: CNT_W] = '0;
			end else if (cnt_inc >= cfg.threshold) begin
				// debounced change
				new_word[c*LANE_W +: LANE_W] = {smp, {CNT_W{1'b0}}};
				new_val[c] = smp;
				key_evt[c] = 1'b1;
				tog_evt[c] = smp && cfg.toggle_en && (key == KEY_IDX_W'(cfg.toggle_key));
			end else begin
				new_word[c*LANE_W +: CNT_W] = cnt_inc;
			end
		end
	end

	// a row holds the toggle key at most once
	assign sw_after = sw ^ (|tog_evt);

	assign rec.row     = row;
	assign rec.key_evt = key_evt;
	assign rec.tog_evt = tog_evt;
	assign rec.new_val = new_val;
	assign rec.sw_prev = sw;

endmodule

@@ rtl/kmd_event_queue.sv @@
// ----------------------------------------------------------------------------
// kmd_event_queue
// record queue and output serializer, one event beat per cycle while out_ch.ready holds
// ----------------------------------------------------------------------------
module kmd_event_queue
	import kmd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  kmd_rec_t       push_rec,
	input  logic           inflight,
	output logic           room,
	kmd_out_if.source      out_ch
);

	kmd_rec_t          fifo [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	kmd_rec_t          cur_q;
	logic [SLOT_N-1:0] pend_q;
	logic              cur_vld_q;

	logic [SLOT_W-1:0]    sel;
	logic [SLOT_N-1:0]    sel_oh;
	logic [SLOT_N-1:0]    pend_left;
	logic [COL_W-1:0]     col;
	logic [MAX_LANES-1:0] upto;
	logic                 beat_done;
	logic                 load;
	logic                 pop;
	logic [SLOT_N-1:0]    load_pend;

	// the beat still in the update stage needs a slot too
	assign room = (cnt_q + QCNT_W'(inflight)) < QCNT_W'(QDEPTH);

	always_comb begin
		sel = '0;
		for (int j = SLOT_N - 1; j >= 0; j--) begin
			if (pend_q[j]) begin
				sel = SLOT_W'(j);
			end
		end
	end

	always_comb begin
		sel_oh      = '0;
		sel_oh[sel] = 1'b1;
	end

	assign pend_left = pend_q & ~sel_oh;
	assign col       = sel[SLOT_W-1:1];

	always_comb begin
		for (int c = 0; c < MAX_LANES; c++) begin
			upto[c] = (COL_W'(c) <= col);
		end
	end

	assign out_ch.valid       = cur_vld_q;
	assign out_ch.event_kind  = sel[0] ? EVT_KEY : EVT_SWITCH;
	assign out_ch.key_row     = cur_q.row;
	assign out_ch.key_column  = col;
	assign out_ch.now_pressed = sel[0] ? cur_q.new_val[col] : 1'b1;
	assign out_ch.switch_on   = cur_q.sw_prev ^ (|(cur_q.tog_evt & upto));
	assign out_ch.last_of_run = (pend_left == '0);

	assign beat_done = cur_vld_q && out_ch.ready && (pend_left == '0);
	assign load      = (cnt_q != '0) && (!cur_vld_q || beat_done);
	assign pop       = load;

	always_comb begin
		for (int c = 0; c < MAX_LANES; c++) begin
			load_pend[2*c]     = fifo[rd_ptr_q].tog_evt[c];
			load_pend[2*c + 1] = fifo[rd_ptr_q].key_evt[c];
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo[wr_ptr_q] <= push_rec;
		end
		if (load) begin
			cur_q <= fifo[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			cnt_q     <= '0;
			pend_q    <= '0;
			cur_vld_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
			if (load) begin
				pend_q    <= load_pend;
				cur_vld_q <= 1'b1;
			end else if (beat_done) begin
				pend_q    <= '0;
				cur_vld_q <= 1'b0;
			end else if (cur_vld_q && out_ch.ready) begin
				pend_q <= pend_left;
			end
		end
	end

endmodule

@@ rtl/key_matrix_debouncer_unit.sv @@
// ----------------------------------------------------------------------------
// key_matrix_debouncer_unit
// debounces a scanned key matrix and reports key and switch events
// ----------------------------------------------------------------------------
// usage:
//  in_ch carries one scanned row per beat: row_index and an active-high mask
//  of pressed columns. out_ch carries event beats: a key state change, or a
//  switch toggle that comes right before the press of the toggle key.
//  last_of_run marks the final event of one row beat; a row that changes no
//  key gives no beat at all.
//  cfg_we/cfg_index/cfg_data write threshold, toggle key and toggle enable;
//  write only while no row beat is in flight.
// timing:
//  a row beat is taken every cycle while the record queue has room. The key
//  state of a row sits in one memory word; the read is registered, update
//  and write-back follow in the stage after it, and each record then passes
//  the record queue and the current-record register on its way out. Events
//  leave at one per cycle while out_ch.ready holds, which sets the rate.
// reset and stall:
//  reset marks every row word as unwritten (all released, counters zero),
//  switch off, registers at their defaults. A stalled output fills a
//  four-record queue, after which in_ch.ready drops.
// ----------------------------------------------------------------------------
module key_matrix_debouncer_unit
	import kmd_pkg::*;
#(
	parameter int ROWS    = ROWS_DEF,
	parameter int COLUMNS = COLUMNS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	kmd_in_if.sink               in_ch,
	kmd_out_if.source            out_ch
);

	// mask only reaches four columns
	localparam int LANES = (COLUMNS < MAX_LANES) ? COLUMNS : MAX_LANES;
	localparam int AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int DW    = LANES * LANE_W;

	// configuration registers
	kmd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold  <= THRESHOLD_RST;
			cfg_q.toggle_key <= '0;
			cfg_q.toggle_en  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD:  cfg_q.threshold  <= cfg_data;
				REG_TOGGLE_KEY: cfg_q.toggle_key <= cfg_data[TKEY_W-1:0];
				REG_TOGGLE_EN:  cfg_q.toggle_en  <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	// input beat and row check
	logic          in_acc;
	logic          row_ok;
	logic [AW-1:0] in_addr;
	logic          room;

	assign in_acc     = in_ch.valid && in_ch.ready;
	assign row_ok     = (4'(in_ch.row_index) < 4'(ROWS));
	assign in_addr    = AW'(in_ch.row_index);
	assign in_ch.ready = room;

	// stage 1: memory read in flight, update and write-back
	logic              v_s1;
	logic              ok_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [AW-1:0]     addr_s1;
	logic [MASK_W-1:0] mask_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ok_s1   <= row_ok;
			row_s1  <= in_ch.row_index;
			addr_s1 <= in_addr;
			mask_s1 <= in_ch.pressed_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
		end
	end

	logic [DW-1:0] mem_rdata;
	logic [DW-1:0] cur_word;
	logic [DW-1:0] new_word;
	logic          we;
	kmd_rec_t      rec;
	logic          sw_q;
	logic          sw_after;

	// last cycle's write-back, for a read that raced it
	logic          wr_vld_q;
	logic [AW-1:0] wr_addr_q;
	logic [DW-1:0] wr_data_q;

	assign we = v_s1 && ok_s1;

	kmd_row_mem #(
		.ROWS  (ROWS),
		.LANES (LANES)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we),
		.waddr  (addr_s1),
		.wdata  (new_word),
		.re     (in_acc && row_ok),
		.raddr  (in_addr),
		.rdata  (mem_rdata)
	);

	// back-to-back beats on one row: the read saw the word before the write
	assign cur_word = (wr_vld_q && (wr_addr_q == addr_s1)) ? wr_data_q : mem_rdata;

	kmd_update #(
		.COLUMNS (COLUMNS),
		.LANES   (LANES)
	) u_update (
		.row_word (cur_word),
		.row      (row_s1),
		.mask     (mask_s1),
		.cfg      (cfg_q),
		.sw       (sw_q),
		.new_word (new_word),
		.rec      (rec),
		.sw_after (sw_after)
	);

	always_ff @(posedge clk) begin
		wr_addr_q <= addr_s1;
		wr_data_q <= new_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
			sw_q     <= 1'b0;
		end else begin
			wr_vld_q <= we;
			if (we) begin
				sw_q <= sw_after;
			end
		end
	end

	// records with at least one event go to the output queue
	logic push;

	assign push = we && (rec.key_evt != '0);

	kmd_event_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (rec),
		.inflight (v_s1),
		.room     (room),
		.out_ch   (out_ch)
	);

	// every accepted row beat reaches the update stage next cycle
	a_beat_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> v_s1)
		else $error("row beat did not reach the update stage");

	// an out-of-range row never writes state
	a_bad_row_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !ok_s1) |=> !wr_vld_q)
		else $error("out-of-range row wrote the key memory");

	// the switch only moves on an update of a valid row
	a_switch_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(sw_q != $past(sw_q)) |-> $past(we))
		else $error("switch state changed without a row update");

	// after a push the output turns valid once the record has passed the queue and cur_q
	a_record_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ##2 out_ch.valid)
		else $error("queued events did not reach the output");

endmodule

@@ verif/key_matrix_debouncer_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_debouncer_unit_test
// self-checking bench for the key matrix debouncer: row scans go in with
// bursts and gaps, event beats come out under a stalling receiver, and a
// scoreboard that carries its own debounce state predicts every event
// ----------------------------------------------------------------------------
module key_matrix_debouncer_unit_test;
	import kmd_pkg::*;

	localparam int KEYS        = ROWS_DEF * COLUMNS_DEF;
	localparam int SETTLE_CYC  = 10;   // covers read, update and the record queue
	localparam int LONG_HOLD   = 80;   // receiver hold-off that fills the block
	localparam int IDLE_LIMIT  = 2000; // cycles with no beat on either channel

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [MASK_W-1:0] mask;
	} scan_beat_t;

	typedef struct packed {
		evt_kind_t        kind;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             pressed;
		logic             sw;
		logic             last;
	} key_event_t;

	// debounce state mirror and the queue of events still to come
	class key_event_scoreboard;
		logic [CNT_W-1:0]  thr;
		logic [TKEY_W-1:0] tkey;
		logic              ten;
		logic              stable [KEYS];
		logic [CNT_W-1:0]  miss_cnt [KEYS];
		logic              sw_mirror;
		key_event_t        pending_events [$];
		int                mismatches;

		function new();
			thr       = THRESHOLD_RST;
			tkey      = '0;
			ten       = 1'b1;
			sw_mirror = 1'b0;
			mismatches = 0;
			foreach (stable[k]) begin
				stable[k]   = 1'b0;
				miss_cnt[k] = '0;
			end
		endfunction

		function void set_config(logic [CNT_W-1:0] t, logic [TKEY_W-1:0] k, logic e);
			thr  = t;
			tkey = k;
			ten  = e;
		endfunction

		function logic [MASK_W-1:0] row_stable(int row);
			logic [MASK_W-1:0] bits;
			bits = '0;
			for (int c = 0; c < COLUMNS_DEF; c++)
				bits[c] = stable[row * COLUMNS_DEF + c];
			return bits;
		endfunction

		// accepted row beat: walk the columns and queue the events it causes
		function void note_scan(logic [ROW_W-1:0] row, logic [MASK_W-1:0] mask);
			key_event_t held;
			bit         have;
			int         key;
			logic       sample;
			have = 0;
			held = '0;
			if (row >= ROWS_DEF)
				return;
			for (int c = 0; c < COLUMNS_DEF; c++) begin
				key    = row * COLUMNS_DEF + c;
				sample = mask[c];
				if (sample == stable[key]) begin
					miss_cnt[key] = '0;
				end else begin
					if (miss_cnt[key] < thr)
						miss_cnt[key] = miss_cnt[key] + 1'b1;
					if (miss_cnt[key] >= thr) begin
						miss_cnt[key] = '0;
						stable[key]   = sample;
						if (sample && ten && key == tkey) begin
							sw_mirror = ~sw_mirror;
							if (have)
								pending_events.push_back(held);
							held = '{EVT_SWITCH, row, COL_W'(c), 1'b1, sw_mirror, 1'b0};
							have = 1;
						end
						if (have)
							pending_events.push_back(held);
						held = '{EVT_KEY, row, COL_W'(c), sample, sw_mirror, 1'b0};
						have = 1;
					end
				end
			end
			if (have) begin
				held.last = 1'b1;
				pending_events.push_back(held);
			end
		endfunction

		function string show(key_event_t e);
			return $sformatf("kind %0d row %0d col %0d pressed %0d switch %0d last %0d",
				e.kind, e.row, e.col, e.pressed, e.sw, e.last);
		endfunction

		function void check_event(key_event_t got);
			key_event_t want;
			if (pending_events.size() == 0) begin
				$display("%0t unexpected event: expected none, actual %s", $time, show(got));
				mismatches++;
				return;
			end
			want = pending_events.pop_front();
			if (got !== want) begin
				$display("%0t event mismatch: expected %s, actual %s",
					$time, show(want), show(got));
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	kmd_in_if  scan_bus();
	kmd_out_if event_bus();

	key_event_scoreboard sb = new();
	scan_beat_t          scan_plan [$];
	bit                  hold_request = 1'b0;
	int                  idle_cycles = 0;

	key_matrix_debouncer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (scan_bus),
		.out_ch    (event_bus)
	);

	always #5 clk = ~clk;

	// beat monitor: predictions on the input side, checks on the output side
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (scan_bus.valid === 1'b1 && scan_bus.ready === 1'b1)
				sb.note_scan(scan_bus.row_index, scan_bus.pressed_mask);
			if (event_bus.valid === 1'b1 && event_bus.ready === 1'b1)
				sb.check_event('{evt_kind_t'(event_bus.event_kind), event_bus.key_row,
					event_bus.key_column, event_bus.now_pressed, event_bus.switch_on,
					event_bus.last_of_run});
		end
	end

	// watchdog: a stuck handshake ends the run
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((scan_bus.valid === 1'b1 && scan_bus.ready === 1'b1) ||
			    (event_bus.valid === 1'b1 && event_bus.ready === 1'b1))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t watchdog: no beat for %0d cycles", $time, idle_cycles);
				$display("== FAIL ==");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: stall pattern redrawn whenever its run ends, one long
	// hold-off when asked so the record queue fills and input ready drops
	initial begin
		int mode;
		int mode_left;
		mode      = 0;
		mode_left = 0;
		event_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				event_bus.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
				event_bus.ready <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				case (mode)
					0: event_bus.ready <= 1'b1;                          // no stalls
					1: event_bus.ready <= 1'($urandom_range(0, 1));      // coin flip
					2: event_bus.ready <= ($urandom_range(0, 7) != 0);   // rare stalls
					default: event_bus.ready <= ((mode_left % 6) >= 3);  // square wave
				endcase
			end
		end
	end

	task automatic push_scan(input int row, input int mask, input int reps);
		for (int i = 0; i < reps; i++)
			scan_plan.push_back('{ROW_W'(row), MASK_W'(mask)});
	endtask

	// well-formed runs: one row held steady for about a threshold's worth of
	// scans with the odd bounce; the rest is short noise and cut-off runs
	task automatic plan_random(input int n_items);
		int thr_eff;
		int kind;
		int row;
		int mask;
		int len;
		int m;
		thr_eff = (sb.thr == 0) ? 1 : int'(sb.thr);
		while (scan_plan.size() < n_items) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				push_scan($urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(1, 3));
			end else begin
				row  = $urandom_range(0, 2);
				mask = $urandom_range(0, 15);
				len  = (kind == 1) ? $urandom_range(1, thr_eff) : thr_eff + $urandom_range(0, 2);
				for (int i = 0; i < len; i++) begin
					m = mask;
					if ($urandom_range(0, 15) == 0)
						m = m ^ (1 << $urandom_range(0, 3));
					push_scan(row, m, 1);
				end
			end
		end
	endtask

	// sender: bursts of random length; with gappy set, random gaps with junk on the data lines
	task automatic drive_plan(input bit gappy);
		scan_beat_t s;
		int         burst;
		int         gap;
		burst = $urandom_range(1, 12);
		while (scan_plan.size() > 0) begin
			s = scan_plan.pop_front();
			scan_bus.valid        <= 1'b1;
			scan_bus.row_index    <= s.row;
			scan_bus.pressed_mask <= s.mask;
			do @(posedge clk); while (scan_bus.ready !== 1'b1);
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 12);
				gap   = gappy ? $urandom_range(0, 5) : 0;
				if (gap > 0 && scan_plan.size() > 0) begin
					scan_bus.valid        <= 1'b0;
					scan_bus.row_index    <= ROW_W'($urandom_range(0, 3));
					scan_bus.pressed_mask <= MASK_W'($urandom_range(0, 15));
					repeat (gap) @(posedge clk);
				end
			end
		end
		scan_bus.valid <= 1'b0;
	endtask

	// block idle: every event in, then a wait for rows that gave none
	task automatic settle();
		while (sb.pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic load_config(input logic [CNT_W-1:0] thr, input logic [TKEY_W-1:0] tkey,
		input logic ten);
		cfg_we    <= 1'b1;
		cfg_index <= REG_THRESHOLD;
		cfg_data  <= thr;
		@(posedge clk);
		cfg_index <= REG_TOGGLE_KEY;
		cfg_data  <= CFG_DAT_W'(tkey);
		@(posedge clk);
		cfg_index <= REG_TOGGLE_EN;
		cfg_data  <= CFG_DAT_W'(ten);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_config(thr, tkey, ten);
	endtask

	initial begin
		logic [MASK_W-1:0] target;
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_index             <= REG_THRESHOLD;
		cfg_data              <= '0;
		scan_bus.valid        <= 1'b0;
		scan_bus.row_index    <= '0;
		scan_bus.pressed_mask <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset defaults: twenty scans press row 0, key 0 is the toggle key,
		// so a switch beat leads; then a row out of range and a lone release
		push_scan(0, 4'hF, 20);
		push_scan(3, 4'hF, 1);
		push_scan(0, 4'h0, 1);
		drive_plan(1'b1);
		settle();

		// zero threshold acts at once; toggle key on the last key
		load_config(8'd0, 4'd11, 1'b1);
		push_scan(2, 4'hF, 1);
		push_scan(2, 4'h0, 1);
		push_scan(1, 4'hA, 1);
		push_scan(0, 4'h0, 1);
		drive_plan(1'b0);
		settle();

		// toggle key that names no key
		load_config(8'd1, 4'd15, 1'b1);
		push_scan(1, 4'hF, 1);
		push_scan(1, 4'h0, 1);
		drive_plan(1'b1);
		settle();

		// toggle disabled: the toggle key is a plain key
		load_config(8'd1, 4'd4, 1'b0);
		push_scan(1, 4'hF, 1);
		push_scan(1, 4'h0, 1);
		drive_plan(1'b1);
		settle();

		for (int p = 0; p < 7; p++) begin
			case (p)
				0: load_config(8'd1, 4'($urandom_range(0, 11)), 1'b1);
				1: load_config(8'd2, 4'($urandom_range(0, 11)), 1'b1);
				2: load_config(8'd3, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
				3: load_config(8'd1, 4'($urandom_range(0, 11)), 1'b1);
				4: load_config(THRESHOLD_RST, 4'($urandom_range(0, 11)), 1'b1);
				5: load_config(8'd255, 4'($urandom_range(8, 11)), 1'b1);
				default: load_config(8'd0, 4'($urandom_range(0, 11)), 1'b1);
			endcase
			if (p == 5) begin
				// full threshold: row 2 flipped for 256 scans, noise on random rows in between
				target = ~sb.row_stable(2);
				for (int i = 0; i < 256; i++) begin
					push_scan(2, target, 1);
					if ($urandom_range(0, 15) == 0)
						push_scan($urandom_range(0, 1) * 2 + 1 - $urandom_range(0, 1),
							$urandom_range(0, 15), 1);
				end
			end else
				plan_random((p == 4) ? 40 : ((p == 3) ? 30 : 15));
			if (p == 3)
				hold_request = 1'b1;   // receiver holds while the sender keeps going
			drive_plan(p != 4);
			settle();
		end

		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
